// ===== sv/c_look_disk_scheduler_assert.svh =====
// Assertion macros for the C-LOOK disk scheduler.
`ifndef C_LOOK_DISK_SCHEDULER_ASSERT_SVH
`define C_LOOK_DISK_SCHEDULER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CLD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cld assertion failed");
`define CLD_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) not (prop)) \
    else $error("cld forbidden condition seen");
`else
`define CLD_ASSERT(lbl, clk, rstn, prop)
`define CLD_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

// ===== sv/cld_pkg.sv =====
package cld_pkg;

  localparam int unsigned MaxBatchDef = 64;
  localparam int unsigned CylW        = 16;
  localparam int unsigned MoveW       = 18;

  typedef enum logic [2:0] {
    StIdle,
    StInsert,
    StScanRd,
    StScanChk,
    StEmitRd,
    StEmitOut
  } state_e;

  typedef struct packed {
    logic accept;
    logic shift;
    logic place;
    logic scan_init;
    logic scan_read;
    logic scan_next;
    logic split_set;
    logic emit_read;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic idx_nz;
    logic gt;
    logic scan_end;
    logic below;
    logic emit_last;
    logic out_free;
    logic last;
  } sts_t;

endpackage

// ===== sv/cld_req_if.sv =====
interface cld_req_if import cld_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CylW-1:0] request_cylinder;
  logic            last_request;

  modport source (output valid, request_cylinder, last_request, input ready);
  modport sink (input valid, request_cylinder, last_request, output ready);
endinterface

// ===== sv/cld_res_if.sv =====
interface cld_res_if import cld_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CylW-1:0]  served_cylinder;
  logic [MoveW-1:0] total_movement;
  logic             last_served;

  modport source (output valid, served_cylinder, total_movement, last_served, input ready);
  modport sink (input valid, served_cylinder, total_movement, last_served, output ready);
endinterface

// ===== sv/cld_ctrl.sv =====
module cld_ctrl import cld_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_last_i,
  input  sts_t sts_i,
  output logic req_ready_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!sts_i.full) begin
            state_d = StInsert;
          end else if (req_last_i) begin
            cmd_o.scan_init = 1'b1;
            state_d         = StScanRd;
          end
        end
      end
      StInsert: begin
        if (sts_i.idx_nz && sts_i.gt) begin
          cmd_o.shift = 1'b1;
        end else begin
          cmd_o.place = 1'b1;
          if (sts_i.last) begin
            cmd_o.scan_init = 1'b1;
            state_d         = StScanRd;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StScanRd: begin
        if (sts_i.scan_end) begin
          cmd_o.split_set = 1'b1;
          state_d         = StEmitRd;
        end else begin
          cmd_o.scan_read = 1'b1;
          state_d         = StScanChk;
        end
      end
      StScanChk: begin
        if (sts_i.below) begin
          cmd_o.scan_next = 1'b1;
          state_d         = StScanRd;
        end else begin
          cmd_o.split_set = 1'b1;
          state_d         = StEmitRd;
        end
      end
      StEmitRd: begin
        cmd_o.emit_read = 1'b1;
        state_d         = StEmitOut;
      end
      StEmitOut: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.emit_last ? StIdle : StEmitRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ===== sv/cld_datapath.sv =====
module cld_datapath import cld_pkg::*; #(
  parameter int unsigned MaxBatch = MaxBatchDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CylW-1:0]  cfg_wdata_i,
  input  logic [CylW-1:0]  req_cyl_i,
  input  logic             req_last_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             res_ready_i,
  output logic             res_valid_o,
  output logic [CylW-1:0]  res_cyl_o,
  output logic [MoveW-1:0] res_move_o,
  output logic             res_last_o
);

  localparam int unsigned CntW  = $clog2(MaxBatch + 1);
  localparam int unsigned AddrW = $clog2(MaxBatch);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxBatch);

  logic [CylW-1:0]  mem [MaxBatch];
  logic [CylW-1:0]  rdata_q;
  logic [CylW-1:0]  start_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  idx_q;
  logic [CntW-1:0]  ptr_q;
  logic [CntW-1:0]  addr_q;
  logic [CntW-1:0]  k_q;
  logic [CylW-1:0]  cyl_q;
  logic             last_q;
  logic [CylW-1:0]  head_q;
  logic [MoveW-1:0] sum_q;
  logic             out_valid_q;
  logic [CylW-1:0]  out_cyl_q;
  logic [MoveW-1:0] out_move_q;
  logic             out_last_q;

  logic [CntW-1:0]  cnt_m1;
  logic [CntW-1:0]  idx_m1;
  logic [CntW-1:0]  idx_m2;
  logic [CntW-1:0]  addr_p1;
  logic             rd_en;
  logic [AddrW-1:0] raddr;
  logic             we;
  logic [CylW-1:0]  wdata;
  logic [CylW-1:0]  step;
  logic [MoveW-1:0] sum_d;

  assign cnt_m1  = count_q - 1'b1;
  assign idx_m1  = idx_q - 1'b1;
  assign idx_m2  = idx_q - CntW'(2);
  assign addr_p1 = addr_q + 1'b1;

  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    if (cmd_i.accept) begin
      rd_en = (count_q != '0);
      raddr = cnt_m1[AddrW-1:0];
    end else if (cmd_i.shift) begin
      rd_en = (idx_q >= CntW'(2));
      raddr = idx_m2[AddrW-1:0];
    end else if (cmd_i.scan_read) begin
      rd_en = 1'b1;
      raddr = ptr_q[AddrW-1:0];
    end else if (cmd_i.emit_read) begin
      rd_en = 1'b1;
      raddr = addr_q[AddrW-1:0];
    end
  end

  assign we    = cmd_i.shift || cmd_i.place;
  assign wdata = cmd_i.shift ? rdata_q : cyl_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q[AddrW-1:0]] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  assign step  = (head_q >= rdata_q) ? (head_q - rdata_q) : (rdata_q - head_q);
  assign sum_d = sum_q + MoveW'(step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      count_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        last_q <= req_last_i;
      end
      if (cmd_i.place) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.emit && sts_o.emit_last) begin
        count_q <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cyl_q <= req_cyl_i;
      idx_q <= count_q;
    end
    if (cmd_i.shift) begin
      idx_q <= idx_m1;
    end
    if (cmd_i.scan_init) begin
      ptr_q  <= '0;
      head_q <= start_q;
      sum_q  <= '0;
    end
    if (cmd_i.scan_next) begin
      ptr_q <= ptr_q + 1'b1;
    end
    if (cmd_i.split_set) begin
      addr_q <= (ptr_q == count_q) ? '0 : ptr_q;
      k_q    <= '0;
    end
    if (cmd_i.emit) begin
      head_q     <= rdata_q;
      sum_q      <= sum_d;
      addr_q     <= (addr_p1 == count_q) ? '0 : addr_p1;
      k_q        <= k_q + 1'b1;
      out_cyl_q  <= rdata_q;
      out_move_q <= sum_d;
      out_last_q <= sts_o.emit_last;
    end
  end

  assign sts_o.full      = (count_q == MaxCnt);
  assign sts_o.cnt_zero  = (count_q == '0);
  assign sts_o.idx_nz    = (idx_q != '0);
  assign sts_o.gt        = (rdata_q > cyl_q);
  assign sts_o.scan_end  = (ptr_q == count_q);
  assign sts_o.below     = (rdata_q < start_q);
  assign sts_o.emit_last = (k_q == cnt_m1);
  assign sts_o.out_free  = !out_valid_q || res_ready_i;
  assign sts_o.last      = last_q;

  assign res_valid_o = out_valid_q;
  assign res_cyl_o   = out_cyl_q;
  assign res_move_o  = out_move_q;
  assign res_last_o  = out_last_q;

endmodule

// ===== sv/c_look_disk_scheduler.sv =====
// C-LOOK disk scheduler.
// Requests arrive on req_i, one cylinder per transfer, and are kept in ascending order
// in an internal memory of MAX_BATCH entries by insertion: a request is taken, then every
// stored entry larger than it moves up one place, and then the request is placed.
// The request flagged last_request starts the schedule; requests beyond MAX_BATCH are
// dropped, but a dropped request flagged last still starts the schedule.
// The schedule first scans the stored requests below start_head, reading and checking
// each in turn, then sends every stored request on res_o in C-LOOK order, each with the
// running head movement, the final one flagged last_served. Each result is first fetched
// through the registered memory read; the block takes no request while it schedules.
// The user writes start_head via cfg_we_i and cfg_wdata_i only while idle; not enforced.
// res_o has an output register: a stalled receiver holds the schedule, nothing is lost.
// Reset clears the request count, start_head and the output valid; the memory
// contents are left undefined, since only written entries are ever read.
`include "c_look_disk_scheduler_assert.svh"

module c_look_disk_scheduler import cld_pkg::*; #(
  parameter int unsigned MAX_BATCH = MaxBatchDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CylW-1:0]  cfg_wdata_i,
  cld_req_if.sink          req_i,
  cld_res_if.source        res_o
);

  cmd_t cmd;
  sts_t sts;

  cld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_last_i  (req_i.last_request),
    .sts_i       (sts),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd)
  );

  cld_datapath #(
    .MaxBatch (MAX_BATCH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_cyl_i   (req_i.request_cylinder),
    .req_last_i  (req_i.last_request),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .res_cyl_o   (res_o.served_cylinder),
    .res_move_o  (res_o.total_movement),
    .res_last_o  (res_o.last_served)
  );

  `CLD_ASSERT(a_emit_needs_free_slot, clk_i, rst_ni, cmd.emit |-> sts.out_free)
  `CLD_ASSERT(a_last_emit_clears_count, clk_i, rst_ni, cmd.emit && sts.emit_last |=> sts.cnt_zero)
  `CLD_ASSERT(a_no_place_when_full, clk_i, rst_ni, cmd.place |-> !sts.full)
  `CLD_ASSERT_NEVER(a_no_request_while_emitting, clk_i, rst_ni, cmd.emit && req_i.ready)

endmodule
